### hw/rtl/bti_pkg.sv
// Package: item types, action and register codes, and controller states for the table interpolator.
package bti_pkg;

  localparam logic [1:0] ACT_WR_ANGLE = 2'd0;
  localparam logic [1:0] ACT_WR_RE    = 2'd1;
  localparam logic [1:0] ACT_WR_TABLE = 2'd2;
  localparam logic [1:0] ACT_LOOKUP   = 2'd3;

  localparam logic CFG_ANGLE_USED = 1'b0;
  localparam logic CFG_RE_USED    = 1'b1;

  localparam int FRAC_W = 17;
  localparam int DIV_LAST = 16;

  typedef struct packed {
    logic [1:0]         action;
    logic [6:0]         row_index;
    logic [3:0]         col_index;
    logic signed [23:0] write_value;
    logic signed [23:0] angle_deg;
    logic [23:0]        reynolds_millions;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] coefficient;
    logic               angle_in_range;
    logic               re_in_range;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_LO,
    ST_HI,
    ST_DIV,
    ST_AXEND,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_CAPT,
    ST_B0M,
    ST_B0A,
    ST_B1M,
    ST_B1A,
    ST_B2M,
    ST_B2A,
    ST_FIN
  } state_t;

endpackage

### hw/rtl/bilinear_table_interpolation_unit.sv
// Top level: bilinear table interpolator with breakpoint search, serial divider and blend.
// A write item (angle breakpoint, Reynolds breakpoint or table entry) is stored when taken. A lookup
// scans the angle breakpoints, then the Reynolds breakpoints, one memory read per cycle; when an
// axis finds a non-empty interval, its fraction is worked out in the shared restoring divider.
// The four table corners are then read, blended with one 18x25 multiplier, and the result is
// registered. A finished result waits in the output register while the next item is taken.
module bilinear_table_interpolation_unit #(
  parameter int ANGLE_POINTS = 128,
  parameter int RE_POINTS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bti_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bti_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);

  localparam int AW = (ANGLE_POINTS > 1) ? $clog2(ANGLE_POINTS) : 1;
  localparam int RW = (RE_POINTS > 1) ? $clog2(RE_POINTS) : 1;
  localparam int KW = ((AW > RW) ? AW : RW) + 1;
  localparam int TD = ANGLE_POINTS * RE_POINTS;
  localparam int TW = $clog2(TD);
  localparam int FW = bti_pkg::FRAC_W;

  bti_pkg::state_t state, state_next;

  logic [7:0] angle_used;
  logic [4:0] re_used;

  logic [23:0] ang_mem [ANGLE_POINTS];
  logic [23:0] re_mem  [RE_POINTS];
  logic [23:0] tab_mem [TD];
  logic [23:0] ang_rdata, re_rdata, tab_rdata;
  logic [TW-1:0] tab_addr, tab_wr_addr;
  logic [KW-1:0] rd_idx;

  logic signed [24:0] av, rv, lo;
  logic [KW-1:0] lim_a, lim_r, k;
  logic axis;
  logic [23:0] den;
  logic [24:0] rem;
  logic [FW-1:0] quo, fa, fr;
  logic [4:0] div_cnt;
  logic [AW-1:0] ia;
  logic [RW-1:0] jr;
  logic afound, rfound;
  logic signed [23:0] c00, c10, c01, c11, c0, c1, res;
  logic signed [42:0] prod;

  logic accept, load;
  logic signed [24:0] cur_v, rd_v;
  logic [KW-1:0] cur_lim, k_inc, k_nxt2;
  logic in_hit, more;
  logic [AW-1:0] ia1;
  logic [RW-1:0] jr1;
  logic cmp;
  logic [24:0] rsub;
  logic [FW-1:0] mul_f;
  logic signed [24:0] mul_d;
  logic signed [23:0] base;
  logic signed [26:0] blend_sum;
  logic signed [23:0] blend_sat;

  assign cfg_ready = !rst;
  assign accept = in_valid && !in_stall;

  assign cur_v   = axis ? rv : av;
  assign cur_lim = axis ? lim_r : lim_a;
  assign rd_v    = axis ? $signed({1'b0, re_rdata}) : $signed({ang_rdata[23], ang_rdata});
  assign in_hit  = (cur_v >= lo) && (cur_v <= rd_v);
  assign k_inc   = k + KW'(1);
  assign k_nxt2  = k + KW'(2);
  assign more    = k_nxt2 < cur_lim;
  assign ia1     = afound ? ia + AW'(1) : '0;
  assign jr1     = rfound ? jr + RW'(1) : '0;

  assign cmp  = rem >= {1'b0, den};
  assign rsub = cmp ? rem - {1'b0, den} : rem;

  assign tab_wr_addr = TW'(in_data.row_index) * TW'(RE_POINTS) + TW'(in_data.col_index);

  always_comb begin
    mul_f = fa;
    mul_d = 25'(c10) - 25'(c00);
    base  = c00;
    case (state)
      bti_pkg::ST_B1M: begin
        mul_d = 25'(c11) - 25'(c01);
      end
      bti_pkg::ST_B1A: begin
        base = c01;
      end
      bti_pkg::ST_B2M: begin
        mul_f = fr;
        mul_d = 25'(c1) - 25'(c0);
      end
      bti_pkg::ST_B2A: begin
        base = c0;
      end
      default: begin
      end
    endcase
  end

  assign blend_sum = 27'(base) + prod[42:16];

  always_comb begin
    if (blend_sum > 27'sd8388607) begin
      blend_sat = 24'sh7FFFFF;
    end else if (blend_sum < -27'sd8388608) begin
      blend_sat = -24'sh800000;
    end else begin
      blend_sat = blend_sum[23:0];
    end
  end

  always_comb begin
    state_next = state;
    in_stall = 1'b1;
    load = 1'b0;
    rd_idx = k_inc;
    tab_addr = TW'(ia) * TW'(RE_POINTS) + TW'(jr);
    case (state)
      bti_pkg::ST_IDLE: begin
        in_stall = rst;
        if (in_valid && in_data.action == bti_pkg::ACT_LOOKUP) begin
          state_next = bti_pkg::ST_START;
        end
      end
      bti_pkg::ST_START: begin
        rd_idx = '0;
        state_next = (cur_lim >= KW'(2)) ? bti_pkg::ST_LO : bti_pkg::ST_AXEND;
      end
      bti_pkg::ST_LO: begin
        state_next = bti_pkg::ST_HI;
      end
      bti_pkg::ST_HI: begin
        if (in_hit) begin
          state_next = (rd_v > lo) ? bti_pkg::ST_DIV : bti_pkg::ST_AXEND;
        end else if (more) begin
          rd_idx = k_nxt2;
        end else begin
          state_next = bti_pkg::ST_AXEND;
        end
      end
      bti_pkg::ST_DIV: begin
        if (div_cnt == 5'(bti_pkg::DIV_LAST)) begin
          state_next = bti_pkg::ST_AXEND;
        end
      end
      bti_pkg::ST_AXEND: begin
        state_next = axis ? bti_pkg::ST_RD0 : bti_pkg::ST_START;
      end
      bti_pkg::ST_RD0: begin
        state_next = bti_pkg::ST_RD1;
      end
      bti_pkg::ST_RD1: begin
        tab_addr = TW'(ia1) * TW'(RE_POINTS) + TW'(jr);
        state_next = bti_pkg::ST_RD2;
      end
      bti_pkg::ST_RD2: begin
        tab_addr = TW'(ia) * TW'(RE_POINTS) + TW'(jr1);
        state_next = bti_pkg::ST_RD3;
      end
      bti_pkg::ST_RD3: begin
        tab_addr = TW'(ia1) * TW'(RE_POINTS) + TW'(jr1);
        state_next = bti_pkg::ST_CAPT;
      end
      bti_pkg::ST_CAPT: state_next = bti_pkg::ST_B0M;
      bti_pkg::ST_B0M: state_next = bti_pkg::ST_B0A;
      bti_pkg::ST_B0A: state_next = bti_pkg::ST_B1M;
      bti_pkg::ST_B1M: state_next = bti_pkg::ST_B1A;
      bti_pkg::ST_B1A: state_next = bti_pkg::ST_B2M;
      bti_pkg::ST_B2M: state_next = bti_pkg::ST_B2A;
      bti_pkg::ST_B2A: state_next = bti_pkg::ST_FIN;
      bti_pkg::ST_FIN: begin
        if (!out_valid || !out_stall) begin
          load = 1'b1;
          state_next = bti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bti_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bti_pkg::ST_IDLE;
      angle_used <= 8'd117;
      re_used <= 5'd11;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bti_pkg::CFG_ANGLE_USED) begin
          angle_used <= cfg_data;
        end else begin
          re_used <= cfg_data[4:0];
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept && in_data.action == bti_pkg::ACT_WR_ANGLE &&
        32'(in_data.row_index) < ANGLE_POINTS) begin
      ang_mem[AW'(in_data.row_index)] <= in_data.write_value;
    end
    if (accept && in_data.action == bti_pkg::ACT_WR_RE &&
        32'(in_data.col_index) < RE_POINTS) begin
      re_mem[RW'(in_data.col_index)] <= in_data.write_value;
    end
    if (accept && in_data.action == bti_pkg::ACT_WR_TABLE &&
        32'(in_data.row_index) < ANGLE_POINTS && 32'(in_data.col_index) < RE_POINTS) begin
      tab_mem[tab_wr_addr] <= in_data.write_value;
    end
    ang_rdata <= ang_mem[rd_idx[AW-1:0]];
    re_rdata  <= re_mem[rd_idx[RW-1:0]];
    tab_rdata <= tab_mem[tab_addr];
  end

  // lookup datapath
  always_ff @(posedge clk) begin
    case (state)
      bti_pkg::ST_IDLE: begin
        av <= {in_data.angle_deg[23], in_data.angle_deg};
        rv <= {1'b0, in_data.reynolds_millions};
        lim_a <= (32'(angle_used) > ANGLE_POINTS) ? KW'(ANGLE_POINTS) : KW'(angle_used);
        lim_r <= (32'(re_used) > RE_POINTS) ? KW'(RE_POINTS) : KW'(re_used);
        axis <= 1'b0;
      end
      bti_pkg::ST_START: begin
        k <= '0;
        if (axis) begin
          rfound <= 1'b0;
          fr <= '0;
          jr <= '0;
        end else begin
          afound <= 1'b0;
          fa <= '0;
          ia <= '0;
        end
      end
      bti_pkg::ST_LO: begin
        lo <= rd_v;
      end
      bti_pkg::ST_HI: begin
        if (in_hit) begin
          if (axis) begin
            rfound <= 1'b1;
            jr <= k[RW-1:0];
          end else begin
            afound <= 1'b1;
            ia <= k[AW-1:0];
          end
          den <= 24'(rd_v - lo);
          rem <= 25'(cur_v - lo);
          quo <= '0;
          div_cnt <= '0;
        end else if (more) begin
          lo <= rd_v;
          k <= k_inc;
        end
      end
      bti_pkg::ST_DIV: begin
        rem <= {rsub[23:0], 1'b0};
        quo <= {quo[FW-2:0], cmp};
        div_cnt <= div_cnt + 5'd1;
        if (div_cnt == 5'(bti_pkg::DIV_LAST)) begin
          if (axis) begin
            fr <= {quo[FW-2:0], cmp};
          end else begin
            fa <= {quo[FW-2:0], cmp};
          end
        end
      end
      bti_pkg::ST_AXEND: begin
        axis <= 1'b1;
      end
      bti_pkg::ST_RD1: c00 <= tab_rdata;
      bti_pkg::ST_RD2: c10 <= tab_rdata;
      bti_pkg::ST_RD3: c01 <= tab_rdata;
      bti_pkg::ST_CAPT: c11 <= tab_rdata;
      bti_pkg::ST_B0M, bti_pkg::ST_B1M, bti_pkg::ST_B2M: begin
        prod <= $signed({1'b0, mul_f}) * mul_d;
      end
      bti_pkg::ST_B0A: c0 <= blend_sat;
      bti_pkg::ST_B1A: c1 <= blend_sat;
      bti_pkg::ST_B2A: res <= blend_sat;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.coefficient <= res;
      out_data.angle_in_range <= afound;
      out_data.re_in_range <= rfound;
    end
  end

`ifndef ASSERT_OFF
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    state != bti_pkg::ST_IDLE |-> in_stall)
    else $error("input taken while a lookup is running");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == bti_pkg::ST_DIV |-> div_cnt <= 5'(bti_pkg::DIV_LAST))
    else $error("divider ran past its last step");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("result register loaded without valid");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    state == bti_pkg::ST_B0M |-> (fa <= 17'h10000 && fr <= 17'h10000))
    else $error("fraction above one");

  a_lookup_start: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.action == bti_pkg::ACT_LOOKUP |=> state == bti_pkg::ST_START)
    else $error("lookup did not start the angle search");
`endif

endmodule

### test/bilinear_table_interpolation_unit_checker.sv
// Checker: watches the item, result and register channels, predicts lookups and compares results.
`timescale 1ns / 1ps
module bilinear_table_interpolation_unit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  bti_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  bti_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 fails,
  output int                 pending
);

  localparam int NA = 128;
  localparam int NR = 16;

  logic signed [23:0] angle_bp [NA];
  logic [23:0]        re_bp [NR];
  logic signed [23:0] coeffs [NA*NR];
  logic [7:0]         angle_used;
  logic [4:0]         re_used;
  bti_pkg::out_item_t expected_q [$];

  function automatic longint mix(longint a, longint b, longint f);
    return a + ((f * (b - a)) >>> 16);
  endfunction

  function automatic bti_pkg::out_item_t interpolate(bti_pkg::in_item_t it);
    bti_pkg::out_item_t r;
    int na, nr, i0, i1, j0, j1;
    longint fa, fr, lo, hi, av, rv, c0, c1, res;
    bit af, rf;
    na = (angle_used > NA) ? NA : angle_used;
    nr = (re_used > NR) ? NR : re_used;
    i0 = 0; i1 = 0; j0 = 0; j1 = 0; fa = 0; fr = 0; af = 0; rf = 0;
    av = longint'(it.angle_deg);
    rv = longint'({40'd0, it.reynolds_millions});
    for (int k = 0; k + 1 < na && !af; k++) begin
      lo = longint'(angle_bp[k]);
      hi = longint'(angle_bp[k+1]);
      if (av >= lo && av <= hi) begin
        i0 = k; i1 = k + 1; af = 1;
        if (hi > lo) fa = ((av - lo) <<< 16) / (hi - lo);
      end
    end
    for (int k = 0; k + 1 < nr && !rf; k++) begin
      lo = longint'({40'd0, re_bp[k]});
      hi = longint'({40'd0, re_bp[k+1]});
      if (rv >= lo && rv <= hi) begin
        j0 = k; j1 = k + 1; rf = 1;
        if (hi > lo) fr = ((rv - lo) <<< 16) / (hi - lo);
      end
    end
    c0 = mix(coeffs[i0*NR+j0], coeffs[i1*NR+j0], fa);
    c1 = mix(coeffs[i0*NR+j1], coeffs[i1*NR+j1], fa);
    res = mix(c0, c1, fr);
    if (res > 8388607) res = 8388607;
    if (res < -8388608) res = -8388608;
    r.coefficient = res[23:0];
    r.angle_in_range = af;
    r.re_in_range = rf;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    bti_pkg::out_item_t e;
    if (rst) begin
      angle_used <= 8'd117;
      re_used <= 5'd11;
      fails <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bti_pkg::CFG_ANGLE_USED) angle_used <= cfg_data;
        else re_used <= cfg_data[4:0];
      end
      if (in_valid && !in_stall) begin
        case (in_data.action)
          bti_pkg::ACT_WR_ANGLE: angle_bp[in_data.row_index] <= in_data.write_value;
          bti_pkg::ACT_WR_RE:    re_bp[in_data.col_index] <= in_data.write_value;
          bti_pkg::ACT_WR_TABLE:
            coeffs[{in_data.row_index, in_data.col_index}] <= in_data.write_value;
          default:      expected_q.insert(expected_q.size(), interpolate(in_data));
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected: got %p", $time, out_data);
          fails <= fails + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.coefficient !== out_data.coefficient ||
              e.angle_in_range !== out_data.angle_in_range ||
              e.re_in_range !== out_data.re_in_range) begin
            $display("%0t: mismatch: expected coef %0d angle_in_range %0b re_in_range %0b,",
                     $time, e.coefficient, e.angle_in_range, e.re_in_range);
            $display("%0t:           actual   coef %0d angle_in_range %0b re_in_range %0b",
                     $time, out_data.coefficient, out_data.angle_in_range,
                     out_data.re_in_range);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

### test/bilinear_table_interpolation_unit_tb.sv
// Testbench top: drives items, register writes and result stalls, and reports the verdict.
`timescale 1ns / 1ps
module bilinear_table_interpolation_unit_tb;

  logic      clk, rst;
  logic      in_valid, in_stall, out_valid, out_stall;
  bti_pkg::in_item_t  in_data;
  bti_pkg::out_item_t out_data;
  logic      cfg_valid, cfg_ready, cfg_index;
  logic [7:0] cfg_data;
  int        fails, pending;
  bit        calm;
  int        hold_req;
  logic signed [23:0] ang_pts [128];
  logic [23:0]        re_pts [16];

  bilinear_table_interpolation_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bilinear_table_interpolation_unit_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  initial clk = 0;
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    #60_000_000;
    $display("bilinear_table_interpolation_unit_tb NOT OK");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    int holds_done;
    out_stall = 0;
    holds_done = 0;
    @(negedge rst);
    forever begin
      if (hold_req > holds_done) begin
        n = 400;
        holds_done++;
      end else begin
        n = calm ? 0 : $urandom_range(0, 10);
      end
      repeat (n) begin
        out_stall <= 1;
        @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic bti_pkg::in_item_t noise_item();
    bti_pkg::in_item_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(bti_pkg::in_item_t)-1:0];
    return it;
  endfunction

  task automatic send(bti_pkg::in_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_item(logic [1:0] act, int row, int col, logic [23:0] v);
    bti_pkg::in_item_t it;
    it = noise_item();
    it.action = act;
    it.row_index = 7'(row);
    it.col_index = 4'(col);
    it.write_value = v;
    if (act == bti_pkg::ACT_WR_ANGLE) ang_pts[row] = v;
    if (act == bti_pkg::ACT_WR_RE) re_pts[col] = v;
    send(it);
  endtask

  task automatic lookup(logic [23:0] a, logic [23:0] r);
    bti_pkg::in_item_t it;
    it = noise_item();
    it.action = bti_pkg::ACT_LOOKUP;
    it.angle_deg = a;
    it.reynolds_millions = r;
    send(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_cfg(logic idx, logic [7:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // angle points above index 15 stay flat, so lookups only reach table rows 0..16
  task automatic load_axes();
    int a;
    int r;
    a = -8388608 + $urandom_range(0, 100000);
    for (int k = 0; k < 128; k++) begin
      write_item(bti_pkg::ACT_WR_ANGLE, k, $urandom_range(0, 15), 24'(a));
      if (k < 15) a += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 120000);
    end
    r = $urandom_range(0, 1000);
    for (int k = 0; k < 16; k++) begin
      write_item(bti_pkg::ACT_WR_RE, $urandom_range(0, 127), k, 24'(r));
      r += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1000000);
    end
  endtask

  function automatic logic [23:0] pick_angle();
    int k;
    k = $urandom_range(0, 20);
    case ($urandom_range(0, 9))
      0: return 24'($urandom);
      1: return ang_pts[k];
      default: return 24'(ang_pts[k] + $urandom_range(0, 120000));
    endcase
  endfunction

  function automatic logic [23:0] pick_re();
    int k;
    k = $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      0: return 24'($urandom);
      1: return re_pts[k];
      default: return 24'(re_pts[k] + $urandom_range(0, 1000000));
    endcase
  endfunction

  task automatic random_phase(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 82) lookup(pick_angle(), pick_re());
      else if (sel < 92) write_item(bti_pkg::ACT_WR_TABLE, $urandom_range(0, 16),
                                    $urandom_range(0, 15), 24'($urandom));
      else if (sel < 96) write_item(bti_pkg::ACT_WR_ANGLE, $urandom_range(0, 14),
                                    $urandom_range(0, 15), pick_angle());
      else write_item(bti_pkg::ACT_WR_RE, $urandom_range(0, 127), $urandom_range(0, 15),
                      pick_re());
    end
    calm = 0;
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = bti_pkg::CFG_ANGLE_USED;
    cfg_data = '0;
    calm = 0;
    hold_req = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // fill every entry that a lookup can reach
    load_axes();
    for (int r = 0; r < 17; r++)
      for (int c = 0; c < 16; c++)
        write_item(bti_pkg::ACT_WR_TABLE, r, c, 24'($urandom));
    write_item(bti_pkg::ACT_WR_TABLE, 0, 0, 24'h7FFFFF);
    write_item(bti_pkg::ACT_WR_TABLE, 1, 0, 24'h800000);
    write_item(bti_pkg::ACT_WR_TABLE, 0, 1, 24'h800000);
    write_item(bti_pkg::ACT_WR_TABLE, 1, 1, 24'h7FFFFF);

    // directed: corners, breakpoints, out of range, zero-width interval
    lookup(ang_pts[0], re_pts[0]);
    lookup(ang_pts[0] + 24'd1, re_pts[0] + 24'd1);
    lookup(ang_pts[1], re_pts[1]);
    lookup(24'h800000, 24'h000000);
    lookup(24'h7FFFFF, 24'hFFFFFF);
    lookup(ang_pts[116], re_pts[10]);
    lookup(ang_pts[127], re_pts[15]);
    write_item(bti_pkg::ACT_WR_ANGLE, 5, 0, ang_pts[4]);
    write_item(bti_pkg::ACT_WR_RE, 0, 3, re_pts[2]);
    lookup(ang_pts[4], re_pts[2]);
    lookup(ang_pts[4] - 24'd1, re_pts[2] + 24'd1);
    drain();
    set_cfg(bti_pkg::CFG_ANGLE_USED, 8'd128);
    set_cfg(bti_pkg::CFG_RE_USED, 8'd16);
    lookup(ang_pts[127], re_pts[15]);
    lookup(ang_pts[126] + 24'd1, re_pts[14] + 24'd1);
    drain();
    set_cfg(bti_pkg::CFG_ANGLE_USED, 8'd0);
    set_cfg(bti_pkg::CFG_RE_USED, 8'd1);
    lookup(ang_pts[3], re_pts[3]);
    drain();
    set_cfg(bti_pkg::CFG_ANGLE_USED, 8'd255);
    set_cfg(bti_pkg::CFG_RE_USED, 8'd31);
    lookup(ang_pts[100], re_pts[7]);
    lookup(24'h7FFFFF, 24'hFFFFFF);
    drain();

    // random phases with different table extents
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          set_cfg(bti_pkg::CFG_ANGLE_USED, 8'd117);
          set_cfg(bti_pkg::CFG_RE_USED, 8'd11);
        end
        1: begin
          set_cfg(bti_pkg::CFG_ANGLE_USED, 8'd2);
          set_cfg(bti_pkg::CFG_RE_USED, 8'd2);
        end
        2: begin
          set_cfg(bti_pkg::CFG_ANGLE_USED, 8'd128);
          set_cfg(bti_pkg::CFG_RE_USED, 8'd16);
        end
        3: begin
          set_cfg(bti_pkg::CFG_ANGLE_USED, 8'd1);
          set_cfg(bti_pkg::CFG_RE_USED, 8'd0);
        end
        default: begin
          set_cfg(bti_pkg::CFG_ANGLE_USED, 8'($urandom));
          set_cfg(bti_pkg::CFG_RE_USED, 8'($urandom));
        end
      endcase
      if (p == 4) load_axes();
      if (p == 2) hold_req = 1;
      random_phase(67);
      drain();
    end

    if (fails == 0) begin
      $display("bilinear_table_interpolation_unit_tb OK");
    end else begin
      $display("bilinear_table_interpolation_unit_tb NOT OK");
    end
    $finish;
  end
endmodule

### bilinear_table_interpolation_unit.f
hw/rtl/bti_pkg.sv
hw/rtl/bilinear_table_interpolation_unit.sv
test/bilinear_table_interpolation_unit_checker.sv
test/bilinear_table_interpolation_unit_tb.sv
